[src/dtwc_pkg.sv]
// ----------------------------------------------------------------------------
// dtwc_pkg
// Shared types and constants for the direct mapped / two-way cache tag check.
// ----------------------------------------------------------------------------
package dtwc_pkg;

    localparam int DEF_ADDR_WIDTH  = 16;
    localparam int DEF_OFFSET_BITS = 6;
    localparam int DEF_DM_LINES    = 8;
    localparam int DEF_SA_SETS     = 4;

    localparam int ADDRESS_W = 16;
    localparam int VALUE_W   = 32;
    localparam int CNT_W     = 32;

    // counter slots
    localparam int CNT_NUM     = 4;
    localparam int CNT_DM_HIT  = 0;
    localparam int CNT_DM_MISS = 1;
    localparam int CNT_SA_HIT  = 2;
    localparam int CNT_SA_MISS = 3;

    typedef struct packed {
        logic [ADDRESS_W-1:0]      address;
        logic signed [VALUE_W-1:0] data_value;
    } in_item_t;

    typedef struct packed {
        logic             direct_hit;
        logic             assoc_hit;
        logic             assoc_way;
        logic [CNT_W-1:0] direct_hits;
        logic [CNT_W-1:0] direct_misses;
        logic [CNT_W-1:0] assoc_hits;
        logic [CNT_W-1:0] assoc_misses;
    } out_item_t;

    typedef struct packed {
        logic direct_hit;
        logic assoc_hit;
        logic assoc_way;
    } lookup_status_t;

endpackage

[src/dtwc_dm_lookup.sv]
// ----------------------------------------------------------------------------
// dtwc_dm_lookup
// Direct mapped tag store: valid bits and tags, lookup and fill on a miss.
// ----------------------------------------------------------------------------
module dtwc_dm_lookup #(
    parameter int ADDR_WIDTH  = 16,
    parameter int OFFSET_BITS = 6,
    parameter int DM_LINES    = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic [ADDR_WIDTH-1:0] addr,
    output logic                  hit
);
    import dtwc_pkg::*;

    // line count must be a power of two, which is not enforced here: index and tag are plain bit fields
    localparam int IDX_W = $clog2(DM_LINES);
    localparam int TAG_W = ADDR_WIDTH - OFFSET_BITS - IDX_W;

    logic [IDX_W-1:0] idx;
    logic [TAG_W-1:0] tag;
    logic [DM_LINES-1:0] valid_reg;
    logic [TAG_W-1:0]    tag_reg [DM_LINES];

    assign idx = addr[OFFSET_BITS +: IDX_W];
    assign tag = addr[ADDR_WIDTH-1 -: TAG_W];
    assign hit = valid_reg[idx] && (tag_reg[idx] == tag);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en && !hit) begin
            valid_reg[idx] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && !hit) begin
            tag_reg[idx] <= tag;
        end
    end

    a_fill_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        en && !hit |=> valid_reg[$past(idx)])
        else $error("direct mapped fill did not set the valid bit");

endmodule

[src/dtwc_sa_lookup.sv]
// ----------------------------------------------------------------------------
// dtwc_sa_lookup
// Two-way set associative tag store with true LRU per set.
// ----------------------------------------------------------------------------
module dtwc_sa_lookup #(
    parameter int ADDR_WIDTH  = 16,
    parameter int OFFSET_BITS = 6,
    parameter int SA_SETS     = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic [ADDR_WIDTH-1:0] addr,
    output logic                  hit,
    output logic                  way
);
    import dtwc_pkg::*;

    localparam int IDX_BITS = $clog2(SA_SETS);
    localparam int IDX_W    = (IDX_BITS > 0) ? IDX_BITS : 1;
    localparam int TAG_W    = ADDR_WIDTH - OFFSET_BITS - IDX_BITS;

    logic [IDX_W-1:0] idx;
    logic [TAG_W-1:0] tag;
    logic [1:0]       valid_reg [SA_SETS];
    logic [TAG_W-1:0] tag_reg   [SA_SETS][2];
    logic [SA_SETS-1:0] lru_reg;
    logic h0;
    logic h1;

    generate
        if (IDX_BITS > 0) begin : g_idx
            assign idx = addr[OFFSET_BITS +: IDX_W];
        end else begin : g_one_set
            assign idx = '0;
        end
    endgenerate

    assign tag = addr[ADDR_WIDTH-1 -: TAG_W];
    assign h0  = valid_reg[idx][0] && (tag_reg[idx][0] == tag);
    assign h1  = valid_reg[idx][1] && (tag_reg[idx][1] == tag);
    assign hit = h0 || h1;

    // on a miss an empty way goes first, else the lru way
    always_comb begin
        if (hit) begin
            way = !h0;
        end else if (!valid_reg[idx][0]) begin
            way = 1'b0;
        end else if (!valid_reg[idx][1]) begin
            way = 1'b1;
        end else begin
            way = lru_reg[idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lru_reg <= '0;
            for (int s = 0; s < SA_SETS; s++) begin
                valid_reg[s] <= 2'b00;
            end
        end else if (en) begin
            lru_reg[idx] <= !way;
            if (!hit) begin
                valid_reg[idx][way] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en && !hit) begin
            tag_reg[idx][way] <= tag;
        end
    end

    a_lru_follows_way: assert property (@(posedge aclk) disable iff (!aresetn)
        en |=> lru_reg[$past(idx)] == !$past(way))
        else $error("lru does not point away from the way just used");

    a_single_way_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        en |-> !(h0 && h1))
        else $error("same tag valid in both ways of a set");

endmodule

[src/dtwc_hit_counters.sv]
// ----------------------------------------------------------------------------
// dtwc_hit_counters
// Four saturating hit and miss counters; gives the counts after this access.
// ----------------------------------------------------------------------------
module dtwc_hit_counters (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      en,
    input  dtwc_pkg::lookup_status_t                  status,
    output logic [dtwc_pkg::CNT_NUM-1:0][dtwc_pkg::CNT_W-1:0] count_next
);
    import dtwc_pkg::*;

    logic [CNT_NUM-1:0][CNT_W-1:0] count_reg;
    logic [CNT_NUM-1:0]            inc;

    always_comb begin
        inc[CNT_DM_HIT]  = status.direct_hit;
        inc[CNT_DM_MISS] = !status.direct_hit;
        inc[CNT_SA_HIT]  = status.assoc_hit;
        inc[CNT_SA_MISS] = !status.assoc_hit;
        for (int i = 0; i < CNT_NUM; i++) begin
            if (en && inc[i] && (count_reg[i] != '1)) begin
                count_next[i] = count_reg[i] + CNT_W'(1);
            end else begin
                count_next[i] = count_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    a_dm_one_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones({count_next[CNT_DM_HIT] != count_reg[CNT_DM_HIT],
                    count_next[CNT_DM_MISS] != count_reg[CNT_DM_MISS]}) <= 1)
        else $error("direct mapped hit and miss counted for one transaction");

endmodule

[src/direct_and_two_way_cache_tag_check.sv]
// ----------------------------------------------------------------------------
// direct_and_two_way_cache_tag_check
// Looks each address up in a direct mapped and a two-way LRU tag store.
// ----------------------------------------------------------------------------
// Takes one transaction per clock while the result channel is not stalled and
// presents one result per transaction: an input register, then one pass of tag
// compare, fill and counter update, then the result register. Both ways of the
// two-way store are compared in parallel and all state is in flip-flops, so
// there is no clearing pass after reset. DM_LINES and SA_SETS must be powers of
// two; index and tag are bit fields of the address above OFFSET_BITS. The four
// counters saturate at all ones, and the counts in a result include that
// transaction. data_value is accepted with the address but never read back.
module direct_and_two_way_cache_tag_check #(
    parameter int ADDR_WIDTH  = dtwc_pkg::DEF_ADDR_WIDTH,
    parameter int OFFSET_BITS = dtwc_pkg::DEF_OFFSET_BITS,
    parameter int DM_LINES    = dtwc_pkg::DEF_DM_LINES,
    parameter int SA_SETS     = dtwc_pkg::DEF_SA_SETS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  dtwc_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output dtwc_pkg::out_item_t m_item
);
    import dtwc_pkg::*;

    in_item_t  in_reg;
    logic      in_valid_reg;
    out_item_t out_reg;
    logic      out_valid_reg;
    out_item_t out_next;
    logic      advance;

    logic [ADDR_WIDTH-1:0]         addr;
    logic                          dm_hit;
    logic                          sa_hit;
    logic                          sa_way;
    lookup_status_t                status;
    logic [CNT_NUM-1:0][CNT_W-1:0] count_next;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign addr    = ADDR_WIDTH'(in_reg.address);

    dtwc_dm_lookup #(
        .ADDR_WIDTH  (ADDR_WIDTH),
        .OFFSET_BITS (OFFSET_BITS),
        .DM_LINES    (DM_LINES)
    ) u_dm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (advance),
        .addr    (addr),
        .hit     (dm_hit)
    );

    dtwc_sa_lookup #(
        .ADDR_WIDTH  (ADDR_WIDTH),
        .OFFSET_BITS (OFFSET_BITS),
        .SA_SETS     (SA_SETS)
    ) u_sa (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (advance),
        .addr    (addr),
        .hit     (sa_hit),
        .way     (sa_way)
    );

    assign status.direct_hit = dm_hit;
    assign status.assoc_hit  = sa_hit;
    assign status.assoc_way  = sa_way;

    dtwc_hit_counters u_cnt (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (advance),
        .status     (status),
        .count_next (count_next)
    );

    always_comb begin
        out_next.direct_hit    = status.direct_hit;
        out_next.assoc_hit     = status.assoc_hit;
        out_next.assoc_way     = status.assoc_way;
        out_next.direct_hits   = count_next[CNT_DM_HIT];
        out_next.direct_misses = count_next[CNT_DM_MISS];
        out_next.assoc_hits    = count_next[CNT_SA_HIT];
        out_next.assoc_misses  = count_next[CNT_SA_MISS];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_item;
        end
        if (advance) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |-> !advance)
        else $error("result register overwritten while stalled");

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the direct mapped / two-way LRU cache tag check.
// ----------------------------------------------------------------------------
// A driver streams accesses from a queue over the valid/ready input channel.
// Each accepted access also goes through a behavioral copy of both tag
// stores, and the expected lookup result is queued. A monitor on the result
// channel compares every transaction field by field with the oldest
// expectation. Directed accesses exercise fills, hits, way selection and LRU
// eviction. Random accesses follow a drifting hot region so that hits,
// conflicts and evictions all occur. Both sides idle at random, and the
// receiver stalls once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dtwc_pkg::*;

    localparam int OFFSET_BITS   = DEF_OFFSET_BITS;
    localparam int DM_LINES      = DEF_DM_LINES;
    localparam int SA_SETS       = DEF_SA_SETS;
    localparam int RANDOM_ITEMS  = 1280;
    localparam int QUIET_TAIL    = 150;
    localparam int LONG_HOLD_AT  = 300;
    localparam int LONG_HOLD     = 64;
    localparam int DRAIN_CYCLES  = 10;
    localparam int TIMEOUT_NS    = 2_000_000;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    direct_and_two_way_cache_tag_check dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    // behavioral copy of the tag stores
    bit               dm_valid [DM_LINES];
    int               dm_tag   [DM_LINES];
    bit               sa_valid [2*SA_SETS];
    int               sa_tag   [2*SA_SETS];
    bit               lru_way  [SA_SETS];
    bit [CNT_W-1:0]   counts   [CNT_NUM];

    in_item_t  pending_accesses[$];
    out_item_t expected_results[$];
    out_item_t want;

    int n_total;
    int n_accepted;
    int n_results;
    int n_errors;
    int send_idle;
    int hold_cycles;
    bit long_hold_done;

    function automatic void bump(input int slot);
        if (counts[slot] != '1) begin
            counts[slot]++;
        end
    endfunction

    function automatic out_item_t predict_lookup(input in_item_t acc);
        int        line;
        int        di;
        int        dtag;
        int        si;
        int        stag;
        int        way;
        bit        h0;
        bit        h1;
        out_item_t r;
        line = acc.address >> OFFSET_BITS;
        di   = line % DM_LINES;
        dtag = line / DM_LINES;
        si   = line % SA_SETS;
        stag = line / SA_SETS;
        r    = '0;

        r.direct_hit = dm_valid[di] && dm_tag[di] == dtag;
        if (r.direct_hit) begin
            bump(CNT_DM_HIT);
        end else begin
            dm_valid[di] = 1'b1;
            dm_tag[di]   = dtag;
            bump(CNT_DM_MISS);
        end

        h0 = sa_valid[2*si]   && sa_tag[2*si]   == stag;
        h1 = sa_valid[2*si+1] && sa_tag[2*si+1] == stag;
        r.assoc_hit = h0 || h1;
        if (r.assoc_hit) begin
            way = h0 ? 0 : 1;
            bump(CNT_SA_HIT);
        end else begin
            // an empty way is taken before the LRU one
            if (!sa_valid[2*si]) begin
                way = 0;
            end else if (!sa_valid[2*si+1]) begin
                way = 1;
            end else begin
                way = lru_way[si];
            end
            sa_valid[2*si+way] = 1'b1;
            sa_tag[2*si+way]   = stag;
            bump(CNT_SA_MISS);
        end
        lru_way[si] = (way == 0);

        r.assoc_way     = (way == 1);
        r.direct_hits   = counts[CNT_DM_HIT];
        r.direct_misses = counts[CNT_DM_MISS];
        r.assoc_hits    = counts[CNT_SA_HIT];
        r.assoc_misses  = counts[CNT_SA_MISS];
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0h, got %0h", name, want_v, got_v);
            n_errors++;
        end
    endtask

    initial begin
        forever #4 aclk = ~aclk;
    end

    // driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_results.push_back(predict_lookup(s_item));
                n_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (send_idle > 0) begin
                    send_idle--;
                    s_valid <= 1'b0;
                end else if (pending_accesses.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (pending_accesses.size() > QUIET_TAIL &&
                             $urandom_range(0, 5) == 0) begin
                    send_idle = $urandom_range(0, 2);
                    s_valid <= 1'b0;
                end else begin
                    s_item  <= pending_accesses.pop_front();
                    s_valid <= 1'b1;
                end
            end
        end
    end

    // monitor and receiver stalls
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                n_results++;
                if (expected_results.size() == 0) begin
                    $error("result transaction with no access outstanding");
                    n_errors++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("direct_hit", 32'(want.direct_hit),
                                32'(m_item.direct_hit));
                    check_field("assoc_hit", 32'(want.assoc_hit),
                                32'(m_item.assoc_hit));
                    check_field("assoc_way", 32'(want.assoc_way),
                                32'(m_item.assoc_way));
                    check_field("direct_hits", want.direct_hits, m_item.direct_hits);
                    check_field("direct_misses", want.direct_misses, m_item.direct_misses);
                    check_field("assoc_hits", want.assoc_hits, m_item.assoc_hits);
                    check_field("assoc_misses", want.assoc_misses, m_item.assoc_misses);
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_ready <= 1'b0;
            end else if (!long_hold_done && n_results >= LONG_HOLD_AT) begin
                // long back-pressure so the pipeline fills and s_ready drops
                long_hold_done = 1'b1;
                hold_cycles = LONG_HOLD - 1;
                m_ready <= 1'b0;
            end else if (n_results < n_total - QUIET_TAIL &&
                         $urandom_range(0, 5) == 0) begin
                hold_cycles = $urandom_range(0, 2);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        logic [15:0] dir_addr [22];
        logic [31:0] dir_data [4];
        logic [15:0] addr;
        logic [15:0] last_addr;
        logic [5:0]  hot_hi;
        logic [31:0] r;

        // fills, repeat hit, second way fill, LRU eviction, hit on way 1,
        // offset extremes, top of the address space
        dir_addr = '{16'h0000, 16'h0000, 16'h0100, 16'h0200, 16'h0100, 16'h0000,
                     16'h003F, 16'hFFFF, 16'hFFC0, 16'hFFFF, 16'h7FFF, 16'h8000,
                     16'h0040, 16'h0080, 16'h00C0, 16'h0140, 16'h0240, 16'h0340,
                     16'h0040, 16'hAAAA, 16'h5555, 16'hFF3F};
        dir_data = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
        foreach (dir_addr[i]) begin
            pending_accesses.push_back('{address: dir_addr[i], data_value: dir_data[i % 4]});
        end

        last_addr = '0;
        hot_hi    = '0;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 128 == 0) begin
                hot_hi = 6'($urandom_range(0, 63));
            end
            r = $urandom;
            case ($urandom_range(0, 9))
                0, 1:    addr = 16'($urandom_range(0, 16'hFFFF));
                2, 3, 4: addr = {last_addr[15:6], r[5:0]};
                default: addr = {hot_hi, r[9:6], r[5:0]};
            endcase
            last_addr = addr;
            pending_accesses.push_back('{address: addr, data_value: $urandom});
        end
        n_total = pending_accesses.size();

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_accesses.size() != 0 || s_valid) @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("checked %0d of %0d accesses, incl. a %0d-cycle output stall",
                 n_results, n_accepted, LONG_HOLD);
        $display("direct: %0d hits %0d misses, two-way: %0d hits %0d misses",
                 counts[CNT_DM_HIT], counts[CNT_DM_MISS],
                 counts[CNT_SA_HIT], counts[CNT_SA_MISS]);
        if (n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
